// File: rtl/pmte_pkg.sv
// shared types and constants for the pixel matrix transform engine
`default_nettype none
package pmte_pkg;
  // largest row or column count; the 4-bit index ports fix it
  localparam int unsigned MAX_DIM = 16;

  // command codes
  localparam logic [3:0] CMD_SIZE   = 4'd0;
  localparam logic [3:0] CMD_WRITE  = 4'd1;
  localparam logic [3:0] CMD_READ   = 4'd2;
  localparam logic [3:0] CMD_SWPROW = 4'd3;
  localparam logic [3:0] CMD_SWPCOL = 4'd4;
  localparam logic [3:0] CMD_REVROW = 4'd5;
  localparam logic [3:0] CMD_REVCOL = 4'd6;
  localparam logic [3:0] CMD_REVDG  = 4'd7;
  localparam logic [3:0] CMD_MIRROW = 4'd8;
  localparam logic [3:0] CMD_MIRCOL = 4'd9;
  localparam logic [3:0] CMD_ROT    = 4'd10;
  localparam logic [3:0] CMD_TRANS  = 4'd11;
  localparam logic [3:0] CMD_SWPNB  = 4'd12;

  // smallest count that allows a neighbourhood swap
  localparam int unsigned NB_MIN_DIM = 6;

  // per-cycle commands from controller to datapath
  typedef struct packed {
    logic load;      // capture operands and clear loop counters
    logic rd_a;      // read location a from the pixel store
    logic rd_b;      // read location b
    logic wr_a;      // write b word from the read port to a
    logic wr_b;      // write held a word to b
    logic step;      // advance loop counters
    logic rot_cp;    // rotate: copy pixel into scratch
    logic rot_rd;    // rotate: read scratch
    logic rot_wr;    // rotate: write scratch word to pixel store
    logic rot_done;  // rotate: swap counts
    logic pix_wr;    // single step: pixel write, or count load for size
    logic done;      // emit result
  } ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic err;       // command rejected
    logic last;      // current pair is the last of the loop
    logic empty;     // loop has no pairs
    logic is_rot;
    logic is_pix;    // size, read or write: single step
  } sts_t;
endpackage
`default_nettype wire

// File: rtl/pixel_matrix_transform_engine_top.sv
// top level of the pixel matrix transform engine
`default_nettype none
// Command-driven pixel matrix engine. Raise start with a command while busy is
// low; one result word appears on read_value_o and error_o for a single cycle with
// done_o high, and cannot be stalled. Size, read and write are a single step; a
// swap loop reads a, reads b, writes a and writes b for each pixel pair through
// the single store port, and rotate copies every pixel into a scratch store,
// then rewrites every pixel from it.
module pixel_matrix_transform_engine_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [3:0] req_type_i,
  input  wire logic [3:0] row_a_i,
  input  wire logic [3:0] col_a_i,
  input  wire logic [3:0] row_b_i,
  input  wire logic [3:0] col_b_i,
  input  wire logic [3:0] diag_offset_i,
  input  wire logic [7:0] pixel_value_i,
  input  wire logic [4:0] num_rows_i,
  input  wire logic [4:0] num_cols_i,
  output logic            done_o,
  output logic [7:0]      read_value_o,
  output logic            error_o
);
  pmte_pkg::ctl_t ctl;
  pmte_pkg::sts_t sts;

  pmte_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .sts_i(sts),
    .busy_o(busy), .ctl_o(ctl)
  );

  pmte_dp u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(ctl), .sts_o(sts),
    .req_type_i(req_type_i), .row_a_i(row_a_i), .col_a_i(col_a_i),
    .row_b_i(row_b_i), .col_b_i(col_b_i), .diag_offset_i(diag_offset_i),
    .pixel_value_i(pixel_value_i), .num_rows_i(num_rows_i), .num_cols_i(num_cols_i),
    .done_o(done_o), .read_value_o(read_value_o), .error_o(error_o)
  );
endmodule
`default_nettype wire

// File: rtl/pmte_ram.sv
// generic single-port ram with registered read
`default_nettype none
module pmte_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write and registered read of the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// File: rtl/pmte_ctrl.sv
// controller state machine sequencing reads and writes of each command
`default_nettype none
module pmte_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire pmte_pkg::sts_t  sts_i,
  output logic                 busy_o,
  output pmte_pkg::ctl_t       ctl_o
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_RDA   = 4'd2;
  localparam logic [3:0] S_RDB   = 4'd3;
  localparam logic [3:0] S_WRA   = 4'd4;
  localparam logic [3:0] S_WRB   = 4'd5;
  localparam logic [3:0] S_CP    = 4'd6;
  localparam logic [3:0] S_CPW   = 4'd7;
  localparam logic [3:0] S_RRD   = 4'd8;
  localparam logic [3:0] S_RWR   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;
  localparam logic [3:0] S_RSW   = 4'd11;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and command decode
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    busy_o  = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctl_o.load = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        priority if (sts_i.err || sts_i.is_pix) begin
          ctl_o.pix_wr = ~sts_i.err;
          ctl_o.rd_a   = ~sts_i.err;
          state_d = S_DONE;
        end else if (sts_i.is_rot) begin
          state_d = sts_i.empty ? S_RSW : S_CP;
        end else if (sts_i.empty) begin
          state_d = S_DONE;
        end else begin
          state_d = S_RDA;
        end
      end
      S_RDA: begin
        ctl_o.rd_a = 1'b1;
        state_d = S_RDB;
      end
      S_RDB: begin
        ctl_o.rd_b = 1'b1;
        state_d = S_WRA;
      end
      S_WRA: begin
        ctl_o.wr_a = 1'b1;
        state_d = S_WRB;
      end
      S_WRB: begin
        ctl_o.wr_b = 1'b1;
        ctl_o.step = 1'b1;
        state_d = sts_i.last ? S_DONE : S_RDA;
      end
      S_CP: begin
        ctl_o.rd_a = 1'b1;
        state_d = S_CPW;
      end
      S_CPW: begin
        ctl_o.rot_cp = 1'b1;
        ctl_o.step   = 1'b1;
        state_d = sts_i.last ? S_RRD : S_CP;
      end
      S_RRD: begin
        ctl_o.rot_rd = 1'b1;
        state_d = S_RWR;
      end
      S_RWR: begin
        ctl_o.rot_wr = 1'b1;
        ctl_o.step   = 1'b1;
        state_d = sts_i.last ? S_RSW : S_RRD;
      end
      S_RSW: begin
        ctl_o.rot_done = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        ctl_o.done = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/pmte_dp.sv
// datapath: operands, counts, loop counters, address generation and stores
`default_nettype none
module pmte_dp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire pmte_pkg::ctl_t ctl_i,
  output pmte_pkg::sts_t      sts_o,
  input  wire logic [3:0]     req_type_i,
  input  wire logic [3:0]     row_a_i,
  input  wire logic [3:0]     col_a_i,
  input  wire logic [3:0]     row_b_i,
  input  wire logic [3:0]     col_b_i,
  input  wire logic [3:0]     diag_offset_i,
  input  wire logic [7:0]     pixel_value_i,
  input  wire logic [4:0]     num_rows_i,
  input  wire logic [4:0]     num_cols_i,
  output logic                done_o,
  output logic [7:0]          read_value_o,
  output logic                error_o
);
  localparam int unsigned IW = $clog2(pmte_pkg::MAX_DIM);
  localparam int unsigned AW = 2 * IW;
  localparam int unsigned Depth = pmte_pkg::MAX_DIM * pmte_pkg::MAX_DIM;
  localparam int unsigned CW = 7;

  // operand registers
  logic [3:0] req_q;
  logic [3:0] ra_q, ca_q, rb_q, cb_q, dg_q;
  logic [7:0] pv_q;
  logic [4:0] nr_q, nc_q;
  logic [4:0] rcnt_q, ccnt_q;
  // loop counters: outer i, inner j
  logic [CW-1:0] i_q, j_q;
  logic          ph2_q;
  logic [7:0] ha_q, hb_q;
  logic [7:0] pdat, sdat;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      req_q <= req_type_i;
      ra_q <= row_a_i; ca_q <= col_a_i;
      rb_q <= row_b_i; cb_q <= col_b_i;
      dg_q <= diag_offset_i; pv_q <= pixel_value_i;
      nr_q <= num_rows_i; nc_q <= num_cols_i;
    end
  end

  // validity of the command against current counts
  logic [CW-1:0] rc, cc, ra, ca, rb, cb, dg;
  logic sq, bad;
  always_comb begin
    rc = CW'(rcnt_q); cc = CW'(ccnt_q);
    ra = CW'(ra_q); ca = CW'(ca_q); rb = CW'(rb_q); cb = CW'(cb_q); dg = CW'(dg_q);
    sq = (rcnt_q == ccnt_q);
    unique case (req_q)
      pmte_pkg::CMD_SIZE:   bad = (nr_q > 5'(pmte_pkg::MAX_DIM)) ||
                                  (nc_q > 5'(pmte_pkg::MAX_DIM));
      pmte_pkg::CMD_WRITE,
      pmte_pkg::CMD_READ:   bad = (ra >= rc) || (ca >= cc);
      pmte_pkg::CMD_SWPROW: bad = (ra >= rc) || (rb >= rc);
      pmte_pkg::CMD_SWPCOL: bad = (ca >= cc) || (cb >= cc);
      pmte_pkg::CMD_REVROW: bad = (ra >= rc);
      pmte_pkg::CMD_REVCOL: bad = (ca >= cc);
      pmte_pkg::CMD_REVDG:  bad = !sq || (dg >= cc);
      pmte_pkg::CMD_MIRROW,
      pmte_pkg::CMD_MIRCOL,
      pmte_pkg::CMD_ROT:    bad = 1'b0;
      pmte_pkg::CMD_TRANS:  bad = !sq;
      pmte_pkg::CMD_SWPNB:  bad = ((rc < CW'(pmte_pkg::NB_MIN_DIM)) &&
                                   (cc < CW'(pmte_pkg::NB_MIN_DIM))) ||
                                  (ra < 1) || (ca < 1) || (ra + 2 > rc) || (ca + 2 > cc) ||
                                  (rb < 1) || (cb < 1) || (rb + 2 > rc) || (cb + 2 > cc);
      default:              bad = 1'b1;
    endcase
  end

  // loop bounds: outer count and inner count
  logic [CW-1:0] on, in_n, hc, hr;
  always_comb begin
    hc = CW'(ccnt_q[4:1]); hr = CW'(rcnt_q[4:1]);
    on = CW'(1); in_n = '0;
    unique case (req_q)
      pmte_pkg::CMD_SWPROW: in_n = cc;
      pmte_pkg::CMD_SWPCOL: in_n = rc;
      pmte_pkg::CMD_REVROW: in_n = hc;
      pmte_pkg::CMD_REVCOL: in_n = hr;
      pmte_pkg::CMD_REVDG:  in_n = CW'((cc - dg) >> 1);
      pmte_pkg::CMD_MIRROW: begin on = rc; in_n = hc; end
      pmte_pkg::CMD_MIRCOL: begin on = cc; in_n = hr; end
      pmte_pkg::CMD_ROT:    begin
        on = ph2_q ? cc : rc; in_n = ph2_q ? rc : cc;
      end
      pmte_pkg::CMD_TRANS:  begin on = rc; in_n = cc; end
      pmte_pkg::CMD_SWPNB:  begin on = CW'(3); in_n = CW'(3); end
      default:              in_n = '0;
    endcase
  end

  // next (i, j); transpose starts each row at j = i + 1, neighbourhood skips the centre
  logic [CW-1:0] ni, nj;
  logic lst, emp;
  always_comb begin
    ni = i_q; nj = j_q + CW'(1);
    if (nj >= in_n) begin
      ni = i_q + CW'(1);
      nj = (req_q == pmte_pkg::CMD_TRANS) ? i_q + CW'(2) : '0;
    end
    if (req_q == pmte_pkg::CMD_TRANS) begin
      if (ni < on && nj >= in_n) begin
        ni = ni + CW'(1); nj = ni + CW'(1);
      end
    end
    if (req_q == pmte_pkg::CMD_SWPNB && ni == 1 && nj == 1) nj = CW'(2);
    lst = (ni >= on);
    if (req_q == pmte_pkg::CMD_TRANS) emp = (rc < 2);
    else emp = (on == 0) || (in_n == 0);
  end

  // pair addresses
  logic [CW-1:0] r1, c1, r2, c2;
  always_comb begin
    r1 = '0; c1 = '0; r2 = '0; c2 = '0;
    unique case (req_q)
      pmte_pkg::CMD_WRITE,
      pmte_pkg::CMD_READ:   begin r1 = ra; c1 = ca; end
      pmte_pkg::CMD_SWPROW: begin r1 = ra; c1 = j_q; r2 = rb; c2 = j_q; end
      pmte_pkg::CMD_SWPCOL: begin r1 = j_q; c1 = ca; r2 = j_q; c2 = cb; end
      pmte_pkg::CMD_REVROW: begin
        r1 = ra; c1 = j_q; r2 = ra; c2 = cc - CW'(1) - j_q;
      end
      pmte_pkg::CMD_REVCOL: begin
        r1 = j_q; c1 = ca; r2 = rc - CW'(1) - j_q; c2 = ca;
      end
      pmte_pkg::CMD_REVDG:  begin
        r1 = j_q; c1 = dg + j_q; r2 = cc - CW'(1) - dg - j_q; c2 = cc - CW'(1) - j_q;
      end
      pmte_pkg::CMD_MIRROW: begin
        r1 = i_q; c1 = j_q; r2 = i_q; c2 = cc - CW'(1) - j_q;
      end
      pmte_pkg::CMD_MIRCOL: begin
        r1 = j_q; c1 = i_q; r2 = rc - CW'(1) - j_q; c2 = i_q;
      end
      pmte_pkg::CMD_ROT:    begin
        r1 = i_q; c1 = j_q; r2 = rc - CW'(1) - j_q; c2 = i_q;
      end
      pmte_pkg::CMD_TRANS:  begin r1 = i_q; c1 = j_q; r2 = j_q; c2 = i_q; end
      pmte_pkg::CMD_SWPNB:  begin
        r1 = ra + i_q - CW'(1); c1 = ca + j_q - CW'(1);
        r2 = rb + i_q - CW'(1); c2 = cb + j_q - CW'(1);
      end
      default: ;
    endcase
  end

  logic [AW-1:0] adr1, adr2;
  assign adr1 = {r1[IW-1:0], c1[IW-1:0]};
  assign adr2 = {r2[IW-1:0], c2[IW-1:0]};

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcnt_q <= '0; ccnt_q <= '0;
      i_q <= '0; j_q <= '0; ph2_q <= 1'b0;
    end else begin
      if (ctl_i.load) begin
        i_q <= '0; j_q <= '0; ph2_q <= 1'b0;
      end else begin
        if (ctl_i.pix_wr && req_q == pmte_pkg::CMD_SIZE) begin
          rcnt_q <= nr_q; ccnt_q <= nc_q;
        end
        if (ctl_i.rot_done) begin
          rcnt_q <= ccnt_q; ccnt_q <= rcnt_q;
        end
        if (ctl_i.step) begin
          if (ctl_i.rot_cp && lst) begin
            ph2_q <= 1'b1; i_q <= '0; j_q <= '0;
          end else begin
            i_q <= ni; j_q <= nj;
          end
        end
        if (ctl_i.done && req_q == pmte_pkg::CMD_TRANS) begin
          i_q <= '0;
        end
      end
    end
  end

  // store ports; the b word reaches the read port in the write-a cycle
  logic          pwe, swe;
  logic [AW-1:0] padr, sadr;
  logic [7:0]    pwd;
  always_comb begin
    pwe = 1'b0; padr = adr1; pwd = hb_q;
    swe = 1'b0; sadr = {i_q[IW-1:0], j_q[IW-1:0]};
    if (ctl_i.rd_a) padr = adr1;
    if (ctl_i.rd_b) padr = adr2;
    if (ctl_i.wr_a) begin pwe = 1'b1; padr = adr1; pwd = pdat; end
    if (ctl_i.wr_b) begin pwe = 1'b1; padr = adr2; pwd = ha_q; end
    if (ctl_i.pix_wr && req_q == pmte_pkg::CMD_WRITE) begin
      pwe = 1'b1; pwd = pv_q;
    end
    if (ctl_i.rot_cp) begin swe = 1'b1; sadr = {i_q[IW-1:0], j_q[IW-1:0]}; end
    if (ctl_i.rot_rd) sadr = adr2;
    if (ctl_i.rot_wr) begin pwe = 1'b1; padr = adr1; pwd = sdat; end
  end

  pmte_ram #(.Width(8), .Depth(Depth)) u_pix (
    .clk_i(clk_i), .we_i(pwe), .addr_i(padr), .wdata_i(pwd), .rdata_o(pdat)
  );
  pmte_ram #(.Width(8), .Depth(Depth)) u_scr (
    .clk_i(clk_i), .we_i(swe), .addr_i(sadr), .wdata_i(pdat), .rdata_o(sdat)
  );

  // hold words read for a swap
  logic rdb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rdb_q <= 1'b0;
    else rdb_q <= ctl_i.rd_b;
  end
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_b) ha_q <= pdat;
    if (rdb_q) hb_q <= pdat;
  end

  // status to the controller; the check is stable for the whole command
  assign sts_o.err   = bad;
  assign sts_o.last  = lst;
  assign sts_o.empty = emp;
  assign sts_o.is_rot = (req_q == pmte_pkg::CMD_ROT);
  assign sts_o.is_pix = (req_q == pmte_pkg::CMD_SIZE) || (req_q == pmte_pkg::CMD_WRITE) ||
                        (req_q == pmte_pkg::CMD_READ);

  // result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else done_o <= ctl_i.done;
  end
  always_ff @(posedge clk_i) begin
    if (ctl_i.done) begin
      error_o <= bad;
      read_value_o <= (!bad && req_q == pmte_pkg::CMD_READ) ? pdat : 8'd0;
    end
  end
endmodule
`default_nettype wire
